### design/sbc_pkg.sv
// shared types and constants of the sphere-box contact block
// depends on nothing; imported by every module of the block
package sbc_pkg;

    localparam int CoordW   = 32;
    localparam int RadW     = 31;
    localparam int SizeW    = 31;
    localparam int MagW     = 32;
    localparam int SqW      = 2 * MagW;
    localparam int RootW    = SqW / 2;
    localparam int IsqSteps = RootW;
    localparam int NormW    = 16;
    localparam int NormFrac = 14;
    localparam int QuoW     = NormFrac + 1;
    localparam int DivSteps = QuoW;
    localparam int NumW     = MagW + NormFrac + 1;
    localparam int ProdW    = QuoW + MagW;
    localparam int CtRound  = 15;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } sbc_axis_t;

    // sideband that rides along the root and divide pipelines
    typedef struct packed {
        logic [2:0][CoordW-1:0] s;
        logic [RadW-1:0]        r;
        logic [2:0][MagW-1:0]   a;
        logic [2:0]             neg;
        logic                   in_box;
        logic                   hit;
    } sbc_side_t;

endpackage

### design/sphere_box_contact.sv
// top level of the sphere against axis-aligned box contact test
// depends on sbc_pkg, sbc_isqrt and sbc_ndiv
//
// One item per clock while the skid entry is empty: in every such cycle a
// new sphere/box pair may enter, and each item gives exactly one result item,
// in order, after 6 setup stages, 32 root stages, 15 divide stages, 2 product
// stages and the output register. The latency is set by the bit-per-stage
// square root and the bit-per-stage normal divider. All stages move together;
// a two-entry output register (main plus skid) lets the pipeline keep taking
// items while a finished result waits, and s_tready is the inverse of the
// skid valid register. On a miss every result field is zero; hit is in m_tuser.
module sphere_box_contact (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
    // box_size_x, box_size_y, box_size_z, zero fill
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z, depth, contact_x, contact_y, contact_z
    output logic [175:0] m_tdata,
    // hit
    output logic [0:0]   m_tuser
);
    import sbc_pkg::*;

    typedef struct packed {
        logic                          hit;
        logic [2:0][NormW-1:0]         normal;
        logic [CoordW-1:0]             depth;
        logic [2:0][CoordW-1:0]        contact;
    } sbc_res_t;

    function automatic logic [CoordW-1:0] sat32(input logic signed [34:0] v);
        logic [CoordW-1:0] res;
        if (v > 35'sd2147483647)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = v[CoordW-1:0];
        end
        return res;
    endfunction

    logic en;
    logic s_fire;

    // input unpacking
    logic [2:0][CoordW-1:0] in_s;
    logic [2:0][CoordW-1:0] in_b;
    logic [2:0][SizeW-1:0]  in_e;
    logic [RadW-1:0]        in_r;

    assign in_s[0] = s_tdata[31:0];
    assign in_s[1] = s_tdata[63:32];
    assign in_s[2] = s_tdata[95:64];
    assign in_r    = s_tdata[126:96];
    assign in_b[0] = s_tdata[158:127];
    assign in_b[1] = s_tdata[190:159];
    assign in_b[2] = s_tdata[222:191];
    assign in_e[0] = s_tdata[253:223];
    assign in_e[1] = s_tdata[284:254];
    assign in_e[2] = s_tdata[315:285];

    assign s_fire = s_tvalid && s_tready;

    // stage 1: relative centre, doubled
    logic                         v1_reg;
    logic [2:0][CoordW-1:0]       s1_reg;
    logic signed [33:0]           p1_reg [3];
    logic [2:0][SizeW-1:0]        e1_reg;
    logic [RadW-1:0]              r1_reg;

    // stage 2: clamped point
    logic                         v2_reg;
    logic [2:0][CoordW-1:0]       s2_reg;
    logic signed [33:0]           p2_reg [3];
    logic signed [33:0]           c2_reg [3];
    logic [2:0][SizeW-1:0]        e2_reg;
    logic [RadW-1:0]              r2_reg;
    logic                         in2_reg;

    // stage 3: face choice when inside
    logic                         v3_reg;
    logic [2:0][CoordW-1:0]       s3_reg;
    logic signed [33:0]           p3_reg [3];
    logic signed [33:0]           c3_reg [3];
    logic [2:0][SizeW-1:0]        e3_reg;
    logic [RadW-1:0]              r3_reg;
    logic                         in3_reg;
    sbc_axis_t                    ax3_reg;

    // stage 4: offset vector magnitudes
    logic                         v4_reg;
    logic [2:0][CoordW-1:0]       s4_reg;
    logic [2:0][MagW-1:0]         a4_reg;
    logic [2:0]                   neg4_reg;
    logic                         far4_reg;
    logic [RadW-1:0]              r4_reg;
    logic                         in4_reg;

    // stage 5: squares
    logic                         v5_reg;
    logic [2:0][CoordW-1:0]       s5_reg;
    logic [2:0][MagW-1:0]         a5_reg;
    logic [2:0][SqW-1:0]          sq5_reg;
    logic [SqW-1:0]               lim5_reg;
    logic [2:0]                   neg5_reg;
    logic                         far5_reg;
    logic [RadW-1:0]              r5_reg;
    logic                         in5_reg;

    // stage 6: squared length and hit test
    logic                         v6_reg;
    logic [SqW-1:0]               sum6_reg;
    sbc_side_t                    side6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_fire;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // combinational values of the setup stages
    logic signed [33:0] p1_next [3];
    logic signed [33:0] c2_next [3];
    logic               in2_next;
    logic [32:0]        amag3 [3];
    sbc_axis_t          ax3_next;
    logic [2:0][MagW-1:0] a4_next;
    logic [2:0]         neg4_next;
    logic               far4_next;
    logic [SqW+1:0]     sum6_next;
    logic               hit6_next;

    always_comb
    begin
        logic signed [32:0] diff;
        logic signed [33:0] ee;
        logic signed [33:0] cadj;
        logic signed [34:0] n;
        logic [34:0]        nmag;
        logic [MagW-1:0]    rr;
        in2_next  = 1'b1;
        far4_next = 1'b0;
        rr        = {r3_reg, 1'b0};
        for (int j = 0; j < 3; j++)
        begin
            diff       = {in_s[j][CoordW-1], in_s[j]} - {in_b[j][CoordW-1], in_b[j]};
            p1_next[j] = {diff, 1'b0};

            ee = {3'b000, e1_reg[j]};
            if (p1_reg[j] < -ee)
            begin
                c2_next[j] = -ee;
            end
            else if (p1_reg[j] > ee)
            begin
                c2_next[j] = ee;
            end
            else
            begin
                c2_next[j] = p1_reg[j];
            end
            if (c2_next[j] != p1_reg[j])
            begin
                in2_next = 1'b0;
            end

            amag3[j] = c2_reg[j][33] ? 33'(-c2_reg[j]) : c2_reg[j][32:0];

            cadj = c3_reg[j];
            if (in3_reg && (ax3_reg == sbc_axis_t'(j)))
            begin
                ee = {3'b000, e3_reg[j]};
                if (c3_reg[j] > 0)
                begin
                    cadj = ee;
                end
                else if (c3_reg[j] < 0)
                begin
                    cadj = -ee;
                end
                else
                begin
                    cadj = '0;
                end
            end
            n            = {cadj[33], cadj} - {p3_reg[j][33], p3_reg[j]};
            nmag         = n[34] ? 35'(-n) : n;
            a4_next[j]   = nmag[MagW-1:0];
            neg4_next[j] = n[34];
            if (nmag > {3'b000, rr})
            begin
                far4_next = 1'b1;
            end
        end

        if ((amag3[0] > amag3[1]) && (amag3[0] > amag3[2]))
        begin
            ax3_next = AXIS_X;
        end
        else if (amag3[1] > amag3[2])
        begin
            ax3_next = AXIS_Y;
        end
        else
        begin
            ax3_next = AXIS_Z;
        end

        sum6_next = {2'b00, sq5_reg[0]} + {2'b00, sq5_reg[1]} + {2'b00, sq5_reg[2]};
        hit6_next = in5_reg || (!far5_reg && (sum6_next <= {2'b00, lim5_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_s;
            e1_reg  <= in_e;
            r1_reg  <= in_r;
            for (int j = 0; j < 3; j++)
            begin
                p1_reg[j] <= p1_next[j];
                p2_reg[j] <= p1_reg[j];
                c2_reg[j] <= c2_next[j];
                p3_reg[j] <= p2_reg[j];
                c3_reg[j] <= c2_reg[j];
                sq5_reg[j] <= a4_reg[j] * a4_reg[j];
            end
            s2_reg  <= s1_reg;
            e2_reg  <= e1_reg;
            r2_reg  <= r1_reg;
            in2_reg <= in2_next;

            s3_reg  <= s2_reg;
            e3_reg  <= e2_reg;
            r3_reg  <= r2_reg;
            in3_reg <= in2_reg;
            ax3_reg <= ax3_next;

            s4_reg   <= s3_reg;
            a4_reg   <= a4_next;
            neg4_reg <= neg4_next;
            far4_reg <= far4_next;
            r4_reg   <= r3_reg;
            in4_reg  <= in3_reg;

            s5_reg   <= s4_reg;
            a5_reg   <= a4_reg;
            lim5_reg <= {r4_reg, 1'b0} * {r4_reg, 1'b0};
            neg5_reg <= neg4_reg;
            far5_reg <= far4_reg;
            r5_reg   <= r4_reg;
            in5_reg  <= in4_reg;

            sum6_reg         <= sum6_next[SqW-1:0];
            side6_reg.s      <= s5_reg;
            side6_reg.r      <= r5_reg;
            side6_reg.a      <= a5_reg;
            side6_reg.neg    <= neg5_reg;
            side6_reg.in_box <= in5_reg;
            side6_reg.hit    <= hit6_next;
        end
    end

    // distance: floor square root of the squared length
    logic            sq_valid;
    logic [RootW-1:0] sq_root;
    sbc_side_t       sq_side;

    sbc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .radicand  (sum6_reg),
        .side_in   (side6_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // unit normal components
    logic                  dv_valid;
    logic [2:0][QuoW-1:0]  dv_quo;
    logic [RootW-1:0]      dv_root;
    sbc_side_t             dv_side;

    sbc_ndiv u_ndiv (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sq_valid),
        .divisor     (sq_root),
        .side_in     (sq_side),
        .out_valid   (dv_valid),
        .quo         (dv_quo),
        .divisor_out (dv_root),
        .side_out    (dv_side)
    );

    // post stage 1: signs, depth and lever length
    logic                    v7_reg;
    logic [2:0][QuoW-1:0]    q7_reg;
    logic [2:0]              sg7_reg;
    logic [CoordW-1:0]       dep7_reg;
    logic [MagW-1:0]         len7_reg;
    logic [2:0][CoordW-1:0]  s7_reg;
    logic                    hit7_reg;

    // post stage 2: products
    logic                    v8_reg;
    logic [2:0][ProdW-1:0]   prod8_reg;
    logic [2:0][QuoW-1:0]    q8_reg;
    logic [2:0]              sg8_reg;
    logic [CoordW-1:0]       dep8_reg;
    logic [2:0][CoordW-1:0]  s8_reg;
    logic                    hit8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= dv_valid;
            v8_reg <= v7_reg;
        end
    end

    logic [RootW-1:0] half_root;
    assign half_root = {1'b0, dv_root[RootW-1:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q7_reg   <= dv_quo;
            sg7_reg  <= dv_side.neg ^ {3{dv_side.in_box}};
            dep7_reg <= sat32(35'({1'b0, dv_side.r}) - 35'(half_root));
            len7_reg <= {1'b0, dv_side.r} + half_root;
            s7_reg   <= dv_side.s;
            hit7_reg <= dv_side.hit;

            for (int j = 0; j < 3; j++)
            begin
                prod8_reg[j] <= q7_reg[j] * len7_reg;
            end
            q8_reg   <= q7_reg;
            sg8_reg  <= sg7_reg;
            dep8_reg <= dep7_reg;
            s8_reg   <= s7_reg;
            hit8_reg <= hit7_reg;
        end
    end

    // rounding of the contact offset and the final result
    sbc_res_t res_next;

    always_comb
    begin
        logic [ProdW:0]        rnd;
        logic [ProdW-CtRound:0] m;
        logic signed [34:0]    v;
        logic signed [34:0]    off;
        res_next.hit   = hit8_reg;
        res_next.depth = hit8_reg ? dep8_reg : '0;
        for (int j = 0; j < 3; j++)
        begin
            rnd = {1'b0, prod8_reg[j]} + (ProdW+1)'(1 << (CtRound - 1));
            m   = rnd[ProdW:CtRound];
            off = sg8_reg[j] ? -35'(m) : 35'(m);
            v   = 35'(signed'(s8_reg[j])) + off;
            res_next.normal[j]  = !hit8_reg ? '0
                                : (sg8_reg[j] ? -NormW'(q8_reg[j]) : NormW'(q8_reg[j]));
            res_next.contact[j] = hit8_reg ? sat32(v) : '0;
        end
    end

    // output register with one skid entry
    logic     out_v_reg;
    logic     skid_v_reg;
    sbc_res_t out_reg;
    sbc_res_t skid_reg;
    logic     out_fire;

    assign out_fire = out_v_reg && m_tready;
    assign en       = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_fire)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg || out_fire)
        begin
            out_v_reg <= v8_reg;
        end
        else if (v8_reg)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_v_reg || out_fire)
        begin
            out_reg <= res_next;
        end
        else
        begin
            skid_reg <= res_next;
        end
    end

    assign s_tready = !skid_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {out_reg.contact[2], out_reg.contact[1], out_reg.contact[0],
                       out_reg.depth,
                       out_reg.normal[2], out_reg.normal[1], out_reg.normal[0]};

    // skid entry is only used behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds an item while output is empty");

    // a miss carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result with nonzero fields");

    // normal components stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(out_reg.normal[0]) <= 16'sd16384)
                   && ($signed(out_reg.normal[0]) >= -16'sd16384)
                   && ($signed(out_reg.normal[1]) <= 16'sd16384)
                   && ($signed(out_reg.normal[1]) >= -16'sd16384)
                   && ($signed(out_reg.normal[2]) <= 16'sd16384)
                   && ($signed(out_reg.normal[2]) >= -16'sd16384)))
        else $error("normal component out of range");

    // a stalled full output with a new item arriving fills the skid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_v_reg && out_v_reg && !m_tready && v8_reg) |=> skid_v_reg)
        else $error("item dropped at output stall");

endmodule

### design/sbc_isqrt.sv
// pipelined floor square root, one result bit per register stage
// depends on sbc_pkg
module sbc_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         radicand,
    input  sbc_pkg::sbc_side_t  side_in,
    output logic                out_valid,
    output logic [31:0]         root,
    output sbc_pkg::sbc_side_t  side_out
);
    import sbc_pkg::*;

    logic              v_reg    [IsqSteps];
    logic [SqW-1:0]    rad_reg  [IsqSteps];
    logic [RootW+1:0]  rem_reg  [IsqSteps];
    logic [RootW-1:0]  root_reg [IsqSteps];
    sbc_side_t         side_reg [IsqSteps];

    genvar k;
    generate
        for (k = 0; k < IsqSteps; k++)
        begin : g_stage
            localparam int Pos = 2 * (IsqSteps - 1 - k);
            logic             v_prev;
            logic [SqW-1:0]   rad_prev;
            logic [RootW+1:0] rem_prev;
            logic [RootW-1:0] root_prev;
            sbc_side_t        side_prev;
            logic [RootW+1:0] trial_rem;
            logic [RootW+1:0] trial;
            logic             take;

            if (k == 0)
            begin : g_first
                assign v_prev    = in_valid;
                assign rad_prev  = radicand;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = side_in;
            end
            else
            begin : g_next
                assign v_prev    = v_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            always_comb
            begin
                trial_rem = {rem_prev[RootW-1:0], rad_prev[Pos+1 -: 2]};
                trial     = {root_prev, 2'b01};
                take      = (trial_rem >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_prev;
                    rem_reg[k]  <= take ? (trial_rem - trial) : trial_rem;
                    root_reg[k] <= {root_prev[RootW-2:0], take};
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[IsqSteps-1];
    assign root      = root_reg[IsqSteps-1];
    assign side_out  = side_reg[IsqSteps-1];

endmodule

### design/sbc_ndiv.sv
// pipelined normal divider: round(a * 2^14 / d) for three axes, one bit per stage
// depends on sbc_pkg
module sbc_ndiv (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [31:0]             divisor,
    input  sbc_pkg::sbc_side_t      side_in,
    output logic                    out_valid,
    output logic [2:0][14:0]        quo,
    output logic [31:0]             divisor_out,
    output sbc_pkg::sbc_side_t      side_out
);
    import sbc_pkg::*;

    logic                       v_reg   [DivSteps];
    logic [2:0][MagW-1:0]       rem_reg [DivSteps];
    logic [2:0][QuoW-1:0]       low_reg [DivSteps];
    logic [2:0][QuoW-1:0]       quo_reg [DivSteps];
    logic [MagW-1:0]            d_reg   [DivSteps];
    sbc_side_t                  side_reg[DivSteps];

    genvar k, i;
    generate
        for (k = 0; k < DivSteps; k++)
        begin : g_stage
            logic                 v_prev;
            logic [2:0][MagW-1:0] rem_prev;
            logic [2:0][QuoW-1:0] low_prev;
            logic [2:0][QuoW-1:0] quo_prev;
            logic [MagW-1:0]      d_prev;
            sbc_side_t            side_prev;
            logic [2:0][MagW-1:0] rem_next;
            logic [2:0][QuoW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                for (i = 0; i < 3; i++)
                begin : g_num
                    logic [NumW-1:0] num;
                    assign num = {1'b0, side_in.a[i], {NormFrac{1'b0}}}
                               + {{(NumW-MagW+1){1'b0}}, divisor[MagW-1:1]};
                    assign rem_prev[i] = num[NumW-1:QuoW];
                    assign low_prev[i] = num[QuoW-1:0];
                end
                assign v_prev    = in_valid;
                assign quo_prev  = '0;
                assign d_prev    = divisor;
                assign side_prev = side_in;
            end
            else
            begin : g_next
                assign v_prev    = v_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign low_prev  = low_reg[k-1];
                assign quo_prev  = quo_reg[k-1];
                assign d_prev    = d_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            for (i = 0; i < 3; i++)
            begin : g_axis
                logic [MagW:0] trial;
                logic [MagW:0] diff;
                logic          take;
                always_comb
                begin
                    trial       = {rem_prev[i], low_prev[i][DivSteps-1-k]};
                    diff        = trial - {1'b0, d_prev};
                    take        = (trial >= {1'b0, d_prev});
                    rem_next[i] = take ? diff[MagW-1:0] : trial[MagW-1:0];
                    quo_next[i] = {quo_prev[i][QuoW-2:0], take};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    low_reg[k]  <= low_prev;
                    quo_reg[k]  <= quo_next;
                    d_reg[k]    <= d_prev;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    // zero length vector gives a zero normal
    assign quo         = (d_reg[DivSteps-1] == '0) ? '0 : quo_reg[DivSteps-1];
    assign out_valid   = v_reg[DivSteps-1];
    assign divisor_out = d_reg[DivSteps-1];
    assign side_out    = side_reg[DivSteps-1];

endmodule

### tb/sbc_checker.sv
// checker for the sphere-box contact block: predicts each result and compares
// depends on no design file; watches both stream channels of the block
`timescale 1ns / 100ps

module sbc_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [319:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [175:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic                hit;
        logic [15:0]         nz;
        logic [15:0]         ny;
        logic [15:0]         nx;
        logic signed [31:0]  depth;
        logic signed [31:0]  cz;
        logic signed [31:0]  cy;
        logic signed [31:0]  cx;
    } contact_t;

    contact_t contact_q[$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic contact_t predict_contact(logic [319:0] d);
        contact_t    o;
        longint      s[3];
        longint      p[3];
        longint      c[3];
        longint      e[3];
        longint      n[3];
        logic [63:0] a[3];
        longint      r;
        logic [63:0] r2;
        logic [63:0] sq;
        logic [63:0] tot;
        logic [63:0] d17;
        longint      dist_v;
        longint      q;
        longint      nrm[3];
        longint      len;
        longint      prod;
        longint      m;
        logic        in_box;
        int          ax;
        o = '0;
        r = longint'(d[126:96]);
        r2 = 64'(r) * 2;
        in_box = 1'b1;
        tot = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = longint'($signed(d[32*i +: 32]));
            p[i] = 2 * (s[i] - longint'($signed(d[127+32*i +: 32])));
            e[i] = longint'(d[223+31*i +: 31]);
            c[i] = p[i] < -e[i] ? -e[i] : (p[i] > e[i] ? e[i] : p[i]);
            if (c[i] != p[i])
                in_box = 1'b0;
        end
        if (in_box)
        begin
            for (int i = 0; i < 3; i++)
                a[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
            if (a[0] > a[1] && a[0] > a[2])
                ax = 0;
            else if (a[1] > a[2])
                ax = 1;
            else
                ax = 2;
            c[ax] = c[ax] > 0 ? e[ax] : (c[ax] < 0 ? -e[ax] : 0);
        end
        for (int i = 0; i < 3; i++)
        begin
            n[i] = c[i] - p[i];
            a[i] = n[i] < 0 ? 64'(-n[i]) : 64'(n[i]);
        end
        if (in_box)
        begin
            for (int i = 0; i < 3; i++)
                tot = tot + a[i] * a[i];
        end
        else
        begin
            // any axis beyond the radius, or an overflowing sum, is a miss
            for (int i = 0; i < 3; i++)
            begin
                if (a[i] > r2)
                    return o;
                sq = a[i] * a[i];
                if (tot + sq < tot)
                    return o;
                tot = tot + sq;
            end
            if (tot > r2 * r2)
                return o;
        end
        d17 = root64(tot);
        dist_v = longint'(d17 >> 1);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (d17 != 0)
                q = longint'((a[i] * 16384 + d17 / 2) / d17);
            if (n[i] < 0)
                q = -q;
            if (in_box)
                q = -q;
            nrm[i] = q;
        end
        len = r + dist_v;
        o.hit = 1'b1;
        o.nx = nrm[0][15:0];
        o.ny = nrm[1][15:0];
        o.nz = nrm[2][15:0];
        o.depth = 32'(sat32(r - dist_v));
        for (int i = 0; i < 3; i++)
        begin
            prod = nrm[i] * len;
            m = ((prod < 0 ? -prod : prod) + (64'sd1 <<< 14)) >>> 15;
            m = sat32(s[i] + (prod < 0 ? -m : m));
            if (i == 0)
                o.cx = m[31:0];
            else if (i == 1)
                o.cy = m[31:0];
            else
                o.cz = m[31:0];
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        contact_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            contact_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                contact_q.push_back(predict_contact(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[47:32], m_tdata[31:16], m_tdata[15:0],
                       m_tdata[79:48], m_tdata[175:144], m_tdata[143:112],
                       m_tdata[111:80]};
                if (contact_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result item %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: hit %b/%b n %h %h %h / %h %h %h",
                                      " d %h/%h c %h %h %h / %h %h %h"},
                                     want.hit, got.hit, want.nx, want.ny, want.nz,
                                     got.nx, got.ny, got.nz, want.depth, got.depth,
                                     want.cx, want.cy, want.cz, got.cx, got.cy, got.cz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= contact_q.size();
        end
    end

endmodule

### tb/tb.sv
// stimulus and verdict for the sphere-box contact block
// depends on sphere_box_contact and sbc_checker
`timescale 1ns / 100ps

module tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;   // sphere xyz, radius, box xyz, size xyz, zero fill
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;   // normal xyz, depth, contact xyz
    logic [0:0]   m_tuser;   // hit
    int           fail_count;
    int           pending;
    int           idle_pct;  // sender gap chance per cycle
    int           stall_pct; // receiver stall chance per cycle
    longint       cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    sphere_box_contact i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    sbc_checker i_checker (.*);

    // receiver stalls at random with the current phase's rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog: far above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(40000)) - 20000) <<< $urandom_range(16);
            default: return 32'($signed($urandom_range(4000000)) - 2000000);
        endcase
    endfunction

    function automatic logic [30:0] pick_len();
        case ($urandom_range(4))
            0: return 31'($urandom);
            1: return 31'($urandom_range(3)) << $urandom_range(30);
            default: return 31'($urandom_range(3000000));
        endcase
    endfunction

    // sends one item, holding valid until taken; gaps follow idle_pct
    task automatic send_pair(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [30:0] r, logic [31:0] bx, logic [31:0] by,
                             logic [31:0] bz, logic [30:0] ex, logic [30:0] ey,
                             logic [30:0] ez);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, ez, ey, ex, bz, by, bx, r, sz, sy, sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // mostly near-touching pairs: sphere offset on each axis by up to half size + radius; one in five fully random
    task automatic send_random();
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [30:0] ex;
        logic [30:0] ey;
        logic [30:0] ez;
        logic [30:0] r;
        bx = pick_coord();
        by = pick_coord();
        bz = pick_coord();
        if ($urandom_range(4) == 0)
            send_pair(pick_coord(), pick_coord(), pick_coord(), pick_len(), bx, by, bz,
                      pick_len(), pick_len(), pick_len());
        else
        begin
            ex = 31'($urandom_range(600000));
            ey = 31'($urandom_range(600000));
            ez = 31'($urandom_range(600000));
            r = 31'($urandom_range(400000));
            send_pair(bx + 32'($signed($urandom_range(2 * (ex/2 + r))) - (ex/2 + r)),
                      by + 32'($signed($urandom_range(2 * (ey/2 + r))) - (ey/2 + r)),
                      bz + 32'($signed($urandom_range(2 * (ez/2 + r))) - (ez/2 + r)),
                      r, bx, by, bz, ex, ey, ez);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, inside faces, zero vector, touching, far apart
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(32'h8000, 0, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(0, 32'hffff8000, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(0, 0, 32'h4000, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(32'h4000, 32'h4000, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(32'h20000, 0, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(32'h20001, 0, 0, 31'h10000, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000);
        send_pair(32'h30000, 32'h40000, 0, 31'h50000, 0, 0, 0, 0, 0, 0);
        send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                  31'h7fffffff);
        send_pair(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        send_pair(32'h7fff0000, 0, 0, 31'h7fffffff, 32'h7ffe0000, 0, 0, 0, 0, 0);
        send_pair(32'h80000000, 0, 0, 31'h7fffffff, 32'h80010000, 0, 0, 0, 0, 0);
        send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                  31'h7fffffff);
        send_pair(32'h55555555, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa,
                  32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 31'h55555555, 31'h2aaaaaaa,
                  31'h55555555);
        send_pair(32'h10000, 32'h10000, 32'h10000, 31'h1, 0, 0, 0, 31'h1, 31'h1, 31'h1);

        // hold off until everything is back
        s_tvalid <= 1'b0;
        while (pending != 0 || i_checker.contact_q.size() != 0)
            @(posedge clk);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                3: begin idle_pct = 35; stall_pct = 35; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            repeat (190)
                send_random();
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
design/sbc_pkg.sv
design/sbc_isqrt.sv
design/sbc_ndiv.sv
design/sphere_box_contact.sv
tb/sbc_checker.sv
tb/tb.sv
